### src/aacd_pkg.sv
// Shared constants and types of the AAC RTP access-unit deframer.
// No dependencies; every other file but aacd_if refers to it by scoped names.
`timescale 1ns / 1ps
package aacd_pkg;
	localparam int MAX_AU_HEADERS  = 16;
	localparam int ADTS_PREFIX_LEN = 7;
	localparam int IDX_W  = (MAX_AU_HEADERS > 1) ? $clog2(MAX_AU_HEADERS) : 1;
	localparam int CNT_W  = $clog2(MAX_AU_HEADERS + 1);
	localparam int SIZE_W = 13;
	localparam int DIV_W  = 32;
	localparam int DCNT_W = $clog2(DIV_W);
	localparam logic [15:0] MAX_STEP_RESET = 16'd100;
	localparam logic [7:0]  SYNC_HI   = 8'hFF;
	localparam logic [7:0]  SYNC_MASK = 8'hF0;
	localparam logic        REG_MAX_STEP = 1'b0;

	typedef enum logic [5:0] {
		ST_WAIT   = 6'b000001,
		ST_LEN    = 6'b000010,
		ST_DIV    = 6'b000100,
		ST_HDR    = 6'b001000,
		ST_SEARCH = 6'b010000,
		ST_DATA   = 6'b100000
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;
endpackage

### src/aacd_if.sv
// Stream interfaces of the deframer: payload bytes in, unit bytes out.
// Depends on nothing.
`timescale 1ns / 1ps
interface aacd_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        packet_start;
	logic [15:0] payload_length;
	logic [31:0] timestamp_ms;
	modport source (output valid, data_byte, packet_start, payload_length, timestamp_ms,
		input ready);
	modport sink (input valid, data_byte, packet_start, payload_length, timestamp_ms,
		output ready);
endinterface

interface aacd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  au_byte;
	logic [3:0]  au_index;
	logic [31:0] au_dts;
	logic        au_first;
	logic        au_last;
	logic        adts_prefix;
	modport source (output valid, au_byte, au_index, au_dts, au_first, au_last, adts_prefix,
		input ready);
	modport sink (input valid, au_byte, au_index, au_dts, au_first, au_last, adts_prefix,
		output ready);
endinterface

### src/aacd_div.sv
// Restoring divider, one quotient bit per cycle, for the per-unit stamp step.
// Depends on aacd_pkg.
`timescale 1ns / 1ps
module aacd_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [aacd_pkg::DIV_W-1:0]      dividend,
	input  logic [aacd_pkg::CNT_W-1:0]      divisor,
	output aacd_pkg::div_stat_t             stat,
	output logic [aacd_pkg::DIV_W-1:0]      quotient
);
	logic [aacd_pkg::DCNT_W-1:0] cnt_q;
	logic                        busy_q, done_q;
	logic [aacd_pkg::CNT_W:0]    rem_q;
	logic [aacd_pkg::CNT_W-1:0]  dvs_q;
	logic [aacd_pkg::DIV_W-1:0]  quo_q;
	logic [aacd_pkg::CNT_W:0]    trial;
	logic                        fits;

	assign trial = {rem_q[aacd_pkg::CNT_W-1:0], quo_q[aacd_pkg::DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == aacd_pkg::DCNT_W'(aacd_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[aacd_pkg::DIV_W-2:0], fits};
			rem_q <= fits ? trial - {1'b0, dvs_q} : trial;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
endmodule

### src/aac_rtp_au_deframer.sv
// Top level of the AAC RTP access-unit deframer: sequencer, header store, APB register.
// Depends on aacd_pkg, aacd_if and aacd_div.
//
// channel  dir  handshake      payload
// in_ch    in   valid/ready    data_byte, packet_start, payload_length, timestamp_ms
// out_ch   out  valid/ready    au_byte, au_index, au_dts, au_first, au_last, adts_prefix
// apb      in   psel/penable   max_timestamp_step at address 0
//
// One payload byte per cycle while the output register can take a result and the sequencer is neither
// dividing nor searching. After the header-count byte, input waits while the serial divider works.
// Input is also held while the search finds each next unit, skipping zero-size headers.
// arst_n clears the sequencer; the header store needs no clearing.
// A stalled output holds in_ch.ready low until the result is taken.
`timescale 1ns / 1ps
module aac_rtp_au_deframer (
	input  logic        clk,
	input  logic        arst_n,
	aacd_in_if.sink     in_ch,
	aacd_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int IW = aacd_pkg::IDX_W;
	localparam int CW = aacd_pkg::CNT_W;
	localparam int SW = aacd_pkg::SIZE_W;

	aacd_pkg::state_t state_q;
	logic [15:0]   max_step_q;
	logic [15:0]   len_q, offset_q;
	logic [7:0]    high_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] sizes_q [aacd_pkg::MAX_AU_HEADERS];
	logic [CW-1:0] search_q;
	logic [IW-1:0] unit_q;
	logic [SW-1:0] left_q, size_q;
	logic [31:0]   prev_q, stamp_q, step_q, dts_q;
	logic [15:0]   sync_q;
	logic          ov_q;
	logic [7:0]    ob_q;
	logic [3:0]    oi_q;
	logic [31:0]   od_q;
	logic          of_q, ol_q, oa_q;

	logic          busy, accept, emit;
	logic [11:0]   count_raw;
	logic [31:0]   base, diff;
	logic          div_start;
	aacd_pkg::div_stat_t div_stat;
	logic [31:0]   quo;
	logic [15:0]   off_n;
	logic [15:0]   pos;
	logic [IW-1:0] hidx;
	logic [SW-1:0] cand, done_b;
	logic          first, last, flag;
	logic [15:0]   sync_n;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == aacd_pkg::REG_MAX_STEP) ? {16'd0, max_step_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_step_q <= aacd_pkg::MAX_STEP_RESET;
		else if (psel && penable && pwrite && paddr[2] == aacd_pkg::REG_MAX_STEP)
			max_step_q <= pwdata[15:0];
	end

	assign busy   = (state_q == aacd_pkg::ST_DIV) || (state_q == aacd_pkg::ST_SEARCH);
	assign in_ch.ready = !busy && (!ov_q || out_ch.ready);
	assign accept = in_ch.valid && in_ch.ready;
	assign emit   = accept && !in_ch.packet_start && state_q == aacd_pkg::ST_DATA
		&& offset_q < len_q;

	assign count_raw = {high_q, in_ch.data_byte[7:4]};
	assign base = (prev_q == 32'd0) ? stamp_q : prev_q;
	assign diff = (stamp_q >= base) ? stamp_q - base : 32'd0;
	assign off_n = offset_q + 16'd1;
	assign pos  = off_n - 16'd3;
	assign hidx = pos[IW:1];
	assign cand = sizes_q[search_q[IW-1:0]];

	assign done_b = size_q - left_q;
	assign first  = done_b == '0;
	assign last   = left_q <= SW'(1);
	always_comb begin
		sync_n = sync_q;
		if (first) sync_n = {in_ch.data_byte, 8'h00};
		else if (done_b == SW'(1)) sync_n = {sync_q[15:8], in_ch.data_byte};
	end
	assign flag = last && size_q > SW'(aacd_pkg::ADTS_PREFIX_LEN)
		&& sync_n[15:8] == aacd_pkg::SYNC_HI
		&& (sync_n[7:0] & aacd_pkg::SYNC_MASK) == aacd_pkg::SYNC_MASK;

	assign div_start = accept && !in_ch.packet_start && state_q == aacd_pkg::ST_LEN
		&& offset_q < len_q && count_raw != 12'd0
		&& count_raw <= 12'(aacd_pkg::MAX_AU_HEADERS)
		&& {1'b0, len_q} >= 17'd2 + {4'd0, count_raw, 1'b0};

	aacd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(diff),
		.divisor(count_raw[CW-1:0]), .stat(div_stat), .quotient(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= aacd_pkg::ST_WAIT;
			offset_q <= '0;
			count_q  <= '0;
			prev_q   <= '0;
			stamp_q  <= '0;
			step_q   <= '0;
			unit_q   <= '0;
			left_q   <= '0;
			sync_q   <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (emit) ov_q <= 1'b1;
			else if (out_ch.ready) ov_q <= 1'b0;
			unique case (state_q)
				aacd_pkg::ST_DIV: begin
					if (div_stat.done) begin
						step_q  <= (quo > {16'd0, max_step_q}) ? 32'd0 : quo;
						state_q <= aacd_pkg::ST_HDR;
					end
				end
				aacd_pkg::ST_SEARCH: begin
					if (search_q >= count_q) begin
						state_q <= aacd_pkg::ST_WAIT;
					end else if (cand == '0) begin
						search_q <= search_q + 1'b1;
					end else if (offset_q > len_q || {3'd0, cand} > len_q - offset_q) begin
						state_q <= aacd_pkg::ST_WAIT;
					end else begin
						unit_q  <= search_q[IW-1:0];
						left_q  <= cand;
						size_q  <= cand;
						dts_q   <= stamp_q + 32'(search_q[IW-1:0] * step_q);
						state_q <= aacd_pkg::ST_DATA;
					end
				end
				default: begin
					if (accept) begin
						if (in_ch.packet_start) begin
							len_q    <= in_ch.payload_length;
							stamp_q  <= in_ch.timestamp_ms;
							offset_q <= 16'd1;
							high_q   <= in_ch.data_byte;
							state_q  <= (in_ch.payload_length < 16'd2) ? aacd_pkg::ST_WAIT
								: aacd_pkg::ST_LEN;
						end else if (state_q == aacd_pkg::ST_WAIT) begin
							// stray byte
						end else if (offset_q >= len_q) begin
							state_q <= aacd_pkg::ST_WAIT;
						end else begin
							offset_q <= off_n;
							if (state_q == aacd_pkg::ST_LEN) begin
								if (div_start) begin
									prev_q  <= stamp_q;
									stamp_q <= base;
									count_q <= count_raw[CW-1:0];
									state_q <= aacd_pkg::ST_DIV;
								end else begin
									state_q <= aacd_pkg::ST_WAIT;
								end
							end else if (state_q == aacd_pkg::ST_HDR) begin
								if (!pos[0]) begin
									high_q <= in_ch.data_byte;
								end else begin
									sizes_q[hidx] <= 13'({high_q, in_ch.data_byte} >> 3);
									if ({1'b0, hidx} + 1'b1 >= count_q) begin
										search_q <= '0;
										state_q  <= aacd_pkg::ST_SEARCH;
									end
								end
							end else begin
								sync_q <= sync_n;
								ob_q   <= in_ch.data_byte;
								oi_q   <= 4'(unit_q);
								od_q   <= dts_q;
								of_q   <= first;
								ol_q   <= last;
								oa_q   <= flag;
								if (last) begin
									left_q   <= '0;
									search_q <= {1'b0, unit_q} + 1'b1;
									state_q  <= aacd_pkg::ST_SEARCH;
								end else begin
									left_q <= left_q - 1'b1;
								end
							end
						end
					end
				end
			endcase
		end
	end

	assign out_ch.valid       = ov_q;
	assign out_ch.au_byte     = ob_q;
	assign out_ch.au_index    = oi_q;
	assign out_ch.au_dts      = od_q;
	assign out_ch.au_first    = of_q;
	assign out_ch.au_last     = ol_q;
	assign out_ch.adts_prefix = oa_q;
endmodule

### test/aacd_tb_checker.sv
// Checker for the AAC RTP access-unit deframer: watches both streams and the APB bus,
// predicts unit bytes and compares them. Depends on aacd_pkg and aacd_if.
`timescale 1ns / 1ps
module aacd_tb_checker (
	input  logic        clk,
	input  logic        arst_n,
	aacd_in_if          in_ch,
	aacd_out_if         out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending,
	output int          checked
);
	typedef enum logic [1:0] {P_WAIT, P_LEN, P_HDR, P_DATA} pphase_t;

	typedef struct packed {
		logic [7:0]  au_byte;
		logic [3:0]  au_index;
		logic [31:0] au_dts;
		logic        au_first;
		logic        au_last;
		logic        adts_prefix;
	} unit_byte_t;

	unit_byte_t unit_bytes_q[$];

	logic [15:0] max_step;
	pphase_t     ph;
	int unsigned hdr_cnt;
	logic [12:0] sizes[aacd_pkg::MAX_AU_HEADERS];
	int unsigned offset, pkt_len, cur_unit, left;
	logic [31:0] prev_ts, step, pkt_ts;
	logic [15:0] sync;
	logic [7:0]  hi_byte;

	function automatic void next_unit(input int unsigned idx);
		while (idx < hdr_cnt && idx < aacd_pkg::MAX_AU_HEADERS && sizes[idx] == 0)
			idx++;
		if (idx >= hdr_cnt || idx >= aacd_pkg::MAX_AU_HEADERS) begin
			ph = P_WAIT;
			return;
		end
		if (offset > pkt_len || sizes[idx] > pkt_len - offset) begin
			ph = P_WAIT;
			return;
		end
		cur_unit = idx;
		left = sizes[idx];
		ph = P_DATA;
	endfunction

	function automatic void deframe_byte(input logic [7:0] b, input logic start,
			input logic [15:0] len, input logic [31:0] ts);
		int unsigned cnt, pos, idx, sz, done;
		logic [31:0] base, diff;
		unit_byte_t r;
		if (start) begin
			pkt_len = len;
			pkt_ts = ts;
			offset = 1;
			hi_byte = b;
			ph = (len < 2) ? P_WAIT : P_LEN;
			return;
		end
		if (ph == P_WAIT)
			return;
		if (offset >= pkt_len) begin
			ph = P_WAIT;
			return;
		end
		offset++;
		case (ph)
			P_LEN: begin
				cnt = {hi_byte, b} >> 4;
				if (cnt == 0 || cnt > aacd_pkg::MAX_AU_HEADERS || pkt_len < 2 + 2 * cnt) begin
					ph = P_WAIT;
					return;
				end
				if (prev_ts == 0)
					prev_ts = pkt_ts;
				base = prev_ts;
				diff = (pkt_ts >= base) ? pkt_ts - base : 32'd0;
				step = diff / cnt;
				if (step > max_step)
					step = 0;
				prev_ts = pkt_ts;
				pkt_ts = base;
				hdr_cnt = cnt;
				ph = P_HDR;
			end
			P_HDR: begin
				pos = offset - 3;
				idx = pos >> 1;
				if (!pos[0]) begin
					hi_byte = b;
				end else begin
					if (idx < aacd_pkg::MAX_AU_HEADERS)
						sizes[idx] = 13'({hi_byte, b} >> 3);
					if (idx + 1 >= hdr_cnt)
						next_unit(0);
				end
			end
			default: begin
				sz = sizes[cur_unit];
				done = sz - left;
				r.au_byte = b;
				r.au_index = cur_unit[3:0];
				r.au_first = (done == 0);
				r.au_last = (left <= 1);
				if (r.au_first)
					sync = {b, 8'h00};
				else if (done == 1)
					sync[7:0] = b;
				r.adts_prefix = r.au_last && sz > aacd_pkg::ADTS_PREFIX_LEN
					&& sync[15:8] == aacd_pkg::SYNC_HI
					&& (sync[7:0] & aacd_pkg::SYNC_MASK) == aacd_pkg::SYNC_MASK;
				r.au_dts = pkt_ts + cur_unit * step;
				unit_bytes_q.push_back(r);
				if (r.au_last) begin
					left = 0;
					next_unit(cur_unit + 1);
				end else begin
					left--;
				end
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		unit_byte_t got, want;
		if (!arst_n) begin
			max_step = aacd_pkg::MAX_STEP_RESET;
			ph = P_WAIT;
			hdr_cnt = 0;
			offset = 0;
			pkt_len = 0;
			cur_unit = 0;
			left = 0;
			prev_ts = 0;
			step = 0;
			pkt_ts = 0;
			sync = 0;
			hi_byte = 0;
			fail_count = 0;
			checked = 0;
			unit_bytes_q.delete();
			pending = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.au_byte, out_ch.au_index, out_ch.au_dts, out_ch.au_first,
					out_ch.au_last, out_ch.adts_prefix};
				if (unit_bytes_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected unit byte transaction: %p", got);
				end else begin
					want = unit_bytes_q.pop_front();
					checked++;
					if (got != want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p, got %p", want, got);
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				deframe_byte(in_ch.data_byte, in_ch.packet_start, in_ch.payload_length,
					in_ch.timestamp_ms);
			if (psel && penable && pwrite && pready && paddr[2] == aacd_pkg::REG_MAX_STEP)
				max_step = pwdata[15:0];
			pending = unit_bytes_q.size();
		end
	end
endmodule

### test/aac_rtp_au_deframer_tb.sv
// Testbench top for the AAC RTP access-unit deframer: builds RTP AU-header packets,
// drives them with random idling, programs the step limit. Depends on aacd_pkg, aacd_if, the top level and checker.
`timescale 1ns / 1ps
module aac_rtp_au_deframer_tb;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	int          fail_count, pending, checked;
	int          src_idle, snk_idle;
	int          cycles, bytes_sent, packets;
	logic [31:0] stamp;

	aacd_in_if  in_ch();
	aacd_out_if out_ch();

	aac_rtp_au_deframer u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	aacd_tb_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .pending(pending), .checked(checked)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= snk_idle);
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic start,
			input logic [15:0] len, input logic [31:0] ts);
		while ($urandom_range(99) < src_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.packet_start <= start;
		in_ch.payload_length <= len;
		in_ch.timestamp_ms <= ts;
		do @(posedge clk); while (!in_ch.ready);
		bytes_sent++;
	endtask

	// mode: 0 clean, 1 trailing junk, 2 truncated length, 3 cut short by next start,
	// 4 header section one byte short
	task automatic send_packet(input int cnt, input int max_sz, input int mode,
			input logic [31:0] ts, input int len_force = -1);
		logic [7:0] q[$];
		int sz[$];
		int len, n, s;
		q.push_back(8'((cnt << 4) >> 8));
		q.push_back(8'(cnt << 4) | 8'($urandom_range(15)));
		for (int i = 0; i < cnt; i++) begin
			s = ($urandom_range(99) < 12) ? 0 : $urandom_range(1, max_sz);
			sz.push_back(s);
			q.push_back(8'((s << 3) >> 8));
			q.push_back(8'(s << 3) | 8'($urandom_range(7)));
		end
		if (cnt <= aacd_pkg::MAX_AU_HEADERS) begin
			foreach (sz[i]) begin
				if ($urandom_range(99) < 40 && sz[i] >= 2) begin
					q.push_back(aacd_pkg::SYNC_HI);
					q.push_back(8'hF0 | 8'($urandom_range(15)));
					for (int j = 2; j < sz[i]; j++) q.push_back(8'($urandom));
				end else begin
					for (int j = 0; j < sz[i]; j++) q.push_back(8'($urandom));
				end
			end
		end
		len = q.size();
		n = q.size();
		case (mode)
			1: for (int j = $urandom_range(1, 4); j > 0; j--) q.push_back(8'($urandom));
			2: len = $urandom_range(2, len);
			3: n = $urandom_range(1, n);
			4: len = 1 + 2 * cnt;
			default: ;
		endcase
		if (len_force >= 0)
			len = len_force;
		if (mode != 3)
			n = q.size();
		for (int i = 0; i < n; i++)
			send_byte(q[i], i == 0, 16'(len), ts);
		packets++;
	endtask

	task automatic wait_drained();
		while (pending != 0) @(posedge clk);
		// leftover header bytes may still sit in the divider or skip search
		repeat (60) @(posedge clk);
	endtask

	task automatic write_max_step(input logic [15:0] v);
		in_ch.valid <= 1'b0;
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {aacd_pkg::REG_MAX_STEP, 2'b00};
		pwdata <= {16'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_phase(input int nbytes, input int step_hint);
		int target, r, cnt;
		target = bytes_sent + nbytes;
		while (bytes_sent < target) begin
			r = $urandom_range(99);
			cnt = ($urandom_range(9) == 0) ? $urandom_range(1, aacd_pkg::MAX_AU_HEADERS)
				: $urandom_range(1, 4);
			if ($urandom_range(9) == 0)
				stamp = $urandom;
			else if ($urandom_range(9) == 0)
				stamp = stamp - $urandom_range(1, 500);
			else
				stamp = stamp + cnt * $urandom_range(0, step_hint + step_hint / 4 + 1);
			if (r < 70)
				send_packet(cnt, 12, $urandom_range(9) < 2 ? 1 : 0, stamp);
			else if (r < 80)
				send_packet(cnt, 12, 2, stamp);
			else if (r < 88)
				send_packet(cnt, 12, 3, stamp);
			else if (r < 92)
				send_packet(cnt, 6, 4, stamp);
			else if (r < 95)
				send_packet($urandom_range(9) < 5 ? 0 : aacd_pkg::MAX_AU_HEADERS + 1, 4, 0,
					stamp);
			else
				send_byte(8'($urandom), 1'b0, 16'($urandom), $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.packet_start = 1'b0;
		in_ch.payload_length = '0;
		in_ch.timestamp_ms = '0;
		out_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycles = 0;
		bytes_sent = 0;
		packets = 0;
		src_idle = 21;
		snk_idle = 72;
		stamp = 32'd1000;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stray bytes, tiny packet, first stamp, sync units around the prefix size
		send_byte(8'hA5, 1'b0, 16'd9, 32'd5);
		send_byte(8'h00, 1'b1, 16'd1, 32'd7);
		send_byte(8'h5A, 1'b0, 16'd1, 32'd7);
		send_packet(2, 8, 0, stamp);
		stamp += 40;
		send_packet(aacd_pkg::MAX_AU_HEADERS, 3, 0, stamp);
		stamp -= 100;
		send_packet(3, 10, 1, stamp);
		send_packet(0, 4, 0, stamp);
		send_packet(aacd_pkg::MAX_AU_HEADERS + 1, 2, 0, stamp);
		send_packet(2, 5, 4, stamp);
		send_packet(4, 20, 3, stamp, 16'hFFFF);
		// a huge header size that can never fit
		send_byte(8'h00, 1'b1, 16'd40, stamp);
		send_byte(8'h10, 1'b0, 16'd40, stamp);
		send_byte(8'hFF, 1'b0, 16'd40, stamp);
		send_byte(8'hFF, 1'b0, 16'd40, stamp);
		stamp = 32'hFFFF_FF00;
		send_packet(3, 9, 0, stamp);
		stamp = 32'hFFFF_FFF0;
		send_packet(3, 9, 0, stamp);

		write_max_step(16'hFFFF);
		random_phase(220, 2000);
		src_idle = 72;
		snk_idle = 21;
		write_max_step(16'h0000);
		random_phase(220, 50);
		src_idle = 0;
		snk_idle = 0;
		write_max_step(16'($urandom_range(1, 300)));
		random_phase(220, 150);

		in_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("sent %0d payload bytes in %0d packets over three idling phases",
			bytes_sent, packets);
		$display("checked %0d unit bytes, %0d failures", checked, fail_count);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
